// File: rtl/core/assert_macros.svh
// assertion macros shared by the interpolator rtl
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LIT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define LIT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/lit_pkg.sv
// types, widths and codes of the table linear interpolator
// no dependencies; used by every module of the block
package lit_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int ACTION_W = 2;
   localparam int ALT_W    = 32;
   localparam int DENS_W   = 24;
   localparam int PRES_W   = 28;
   localparam int STAT_W   = 2;
   localparam int TOTAL_W  = 5;

   localparam int VAL_W  = PRES_W;
   localparam int QUOT_W = VAL_W;
   localparam int NUM_W  = ALT_W + VAL_W;
   localparam int QCNT_W = $clog2(QUOT_W + 1);

   localparam int REQ_FIELDS_W = ALT_W + DENS_W + PRES_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = DENS_W + PRES_W + TOTAL_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   // 1.225 kg/m^3 in Q4.20, 101325 Pa in Q20.8
   localparam logic [DENS_W-1:0] DEF_DENSITY  = 24'd1284506;
   localparam logic [PRES_W-1:0] DEF_PRESSURE = 28'd25939200;

   typedef struct packed {
      logic [ALT_W-1:0]  alt;
      logic [DENS_W-1:0] dens;
      logic [PRES_W-1:0] pres;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: rtl/core/lit_table.sv
// breakpoint table memory: one write port, one registered read port
// depends on lit_pkg
module lit_table (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [lit_pkg::IDX_W-1:0]      wr_addr,
   input  lit_pkg::entry_type             wr_data,
   input  logic [lit_pkg::IDX_W-1:0]      rd_addr,
   output lit_pkg::entry_type             rd_data
);

   lit_pkg::entry_type mem [lit_pkg::TABLE_DEPTH];
   lit_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lit_div.sv
// restoring divider, one quotient bit per cycle; quotient must fit QUOT_W bits
// depends on lit_pkg
module lit_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lit_pkg::NUM_W-1:0]    dividend,
   input  logic [lit_pkg::ALT_W-1:0]    divisor,
   output logic [lit_pkg::QUOT_W-1:0]   quotient,
   output lit_pkg::div_stat_type        stat
);

   localparam int REM_W = lit_pkg::NUM_W - lit_pkg::QUOT_W;

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [lit_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   logic [REM_W-1:0]             rem_ff, rem_in;
   logic [lit_pkg::QUOT_W-1:0]   sh_ff, sh_in;
   logic [lit_pkg::ALT_W-1:0]    den_ff, den_in;
   logic [REM_W:0]               partial;
   logic [REM_W:0]               trial;

   assign partial = {rem_ff, sh_ff[lit_pkg::QUOT_W-1]};
   assign trial   = partial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = lit_pkg::QCNT_W'(lit_pkg::QUOT_W);
         rem_in  = dividend[lit_pkg::NUM_W-1:lit_pkg::QUOT_W];
         sh_in   = dividend[lit_pkg::QUOT_W-1:0];
         den_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[REM_W]) begin
            rem_in = trial[REM_W-1:0];
            sh_in  = {sh_ff[lit_pkg::QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = partial[REM_W-1:0];
            sh_in  = {sh_ff[lit_pkg::QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == lit_pkg::QCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
   end

   assign quotient  = sh_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: rtl/core/table_linear_interpolator_top.sv
// top level of the table linear interpolator: sequencer, multiplier, result register
// depends on lit_pkg, lit_table, lit_div and assert_macros.svh
//
// Clear, append and unused-action items, and a query on an empty table, take no table
// read. A query reads the first point, then the last point, and clamps to whichever it
// lies at or beyond. A query inside the table steps through the single read port of the
// breakpoint memory one interval at a time, then runs density and pressure in turn
// through one multiplier and one shared restoring divider, which gives 28 quotient bits
// for each quantity. A zero-width bracket skips the divider.
// A new item is taken once the previous one has moved to the result register.

`include "assert_macros.svh"

module table_linear_interpolator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // altitude, point_density, point_pressure, zero pad
   input  logic [lit_pkg::REQ_DATA_W-1:0]      req_tdata,
   // action
   input  logic [lit_pkg::ACTION_W-1:0]        req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // density, pressure, point_total, zero pad
   output logic [lit_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status
   output logic [lit_pkg::STAT_W-1:0]          rsp_tuser
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_FETCH0  = 4'd1;
   localparam logic [3:0] S_CHK0    = 4'd2;
   localparam logic [3:0] S_CHKL    = 4'd3;
   localparam logic [3:0] S_FETCH   = 4'd4;
   localparam logic [3:0] S_SCAN    = 4'd5;
   localparam logic [3:0] S_MUL     = 4'd6;
   localparam logic [3:0] S_DIVGO   = 4'd7;
   localparam logic [3:0] S_DIVWAIT = 4'd8;
   localparam logic [3:0] S_FINISH  = 4'd9;

   localparam int ALT_W  = lit_pkg::ALT_W;
   localparam int DENS_W = lit_pkg::DENS_W;
   localparam int PRES_W = lit_pkg::PRES_W;
   localparam int VAL_W  = lit_pkg::VAL_W;

   logic [3:0]                      state_ff, state_in;
   logic [lit_pkg::CNT_W-1:0]       points_ff, points_in;
   logic [lit_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic                            sel_ff, sel_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic [ALT_W-1:0]                x_ff, x_in;
   lit_pkg::entry_type              lo_ff, lo_in;
   lit_pkg::entry_type              hi_ff, hi_in;
   logic [lit_pkg::NUM_W-1:0]       prod_ff, prod_in;
   logic                            neg_ff, neg_in;
   logic [ALT_W-1:0]                den_ff, den_in;
   logic [VAL_W-1:0]                v1_ff, v1_in;
   logic [DENS_W-1:0]               dres_ff, dres_in;
   logic [PRES_W-1:0]               pres_ff, pres_in;
   logic [lit_pkg::STAT_W-1:0]      stat_ff, stat_in;
   logic [DENS_W-1:0]               rsp_dens_ff, rsp_dens_in;
   logic [PRES_W-1:0]               rsp_pres_ff, rsp_pres_in;
   logic [lit_pkg::STAT_W-1:0]      rsp_stat_ff, rsp_stat_in;
   logic [lit_pkg::TOTAL_W-1:0]     rsp_total_ff, rsp_total_in;

   logic                            accept;
   logic [lit_pkg::ACTION_W-1:0]    in_action;
   logic [ALT_W-1:0]                in_alt;
   logic [DENS_W-1:0]               in_dens;
   logic [PRES_W-1:0]               in_pres;
   logic [lit_pkg::IDX_W-1:0]       last_idx;

   logic                            wr_en;
   lit_pkg::entry_type              wr_data;
   lit_pkg::entry_type              rd_data;

   logic                            div_start;
   logic [lit_pkg::QUOT_W-1:0]      div_quot;
   lit_pkg::div_stat_type           div_stat;

   logic [VAL_W-1:0]                v1, v2;
   logic [VAL_W:0]                  dv;
   logic [VAL_W-1:0]                dv_mag;
   logic [ALT_W:0]                  dx;
   logic [ALT_W:0]                  den;
   logic [VAL_W-1:0]                div_res;
   logic                            x_le_rd, x_ge_rd, x_ge_lo;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_action  = req_tuser;
   assign in_alt     = req_tdata[ALT_W-1:0];
   assign in_dens    = req_tdata[ALT_W+DENS_W-1:ALT_W];
   assign in_pres    = req_tdata[ALT_W+DENS_W+PRES_W-1:ALT_W+DENS_W];
   assign last_idx   = lit_pkg::IDX_W'(points_ff - 1'b1);

   assign wr_data.alt  = in_alt;
   assign wr_data.dens = in_dens;
   assign wr_data.pres = in_pres;

   assign x_le_rd = $signed(x_ff) <= $signed(rd_data.alt);
   assign x_ge_rd = $signed(x_ff) >= $signed(rd_data.alt);
   assign x_ge_lo = $signed(x_ff) >= $signed(lo_ff.alt);

   // interval arithmetic on the bracketing pair
   assign v1     = sel_ff ? lo_ff.pres : VAL_W'(lo_ff.dens);
   assign v2     = sel_ff ? hi_ff.pres : VAL_W'(hi_ff.dens);
   assign dv     = {1'b0, v2} - {1'b0, v1};
   assign dv_mag = dv[VAL_W] ? VAL_W'(-dv) : dv[VAL_W-1:0];
   assign dx     = {x_ff[ALT_W-1], x_ff} - {lo_ff.alt[ALT_W-1], lo_ff.alt};
   assign den    = {hi_ff.alt[ALT_W-1], hi_ff.alt} - {lo_ff.alt[ALT_W-1], lo_ff.alt};
   assign div_res = neg_ff ? (v1_ff - div_quot) : (v1_ff + div_quot);

   always_comb begin
      state_in     = state_ff;
      points_in    = points_ff;
      idx_in       = idx_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      x_in         = x_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      v1_in        = v1_ff;
      dres_in      = dres_ff;
      pres_in      = pres_ff;
      stat_in      = stat_ff;
      rsp_dens_in  = rsp_dens_ff;
      rsp_pres_in  = rsp_pres_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_total_in = rsp_total_ff;
      wr_en        = 1'b0;
      div_start    = 1'b0;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in     = in_alt;
               dres_in  = '0;
               pres_in  = '0;
               stat_in  = lit_pkg::STAT_OK;
               state_in = S_FINISH;
               unique case (in_action)
                  lit_pkg::ACT_CLEAR: begin
                     points_in = '0;
                  end
                  lit_pkg::ACT_APPEND: begin
                     if (points_ff < lit_pkg::CNT_W'(lit_pkg::TABLE_DEPTH)) begin
                        wr_en     = 1'b1;
                        points_in = points_ff + 1'b1;
                     end else begin
                        stat_in = lit_pkg::STAT_FULL;
                     end
                  end
                  lit_pkg::ACT_QUERY: begin
                     if (points_ff == '0) begin
                        dres_in = lit_pkg::DEF_DENSITY;
                        pres_in = lit_pkg::DEF_PRESSURE;
                        stat_in = lit_pkg::STAT_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_FETCH0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FETCH0: begin
            idx_in   = last_idx;
            state_in = S_CHK0;
         end
         S_CHK0: begin
            lo_in = rd_data;
            if (x_le_rd) begin
               dres_in  = rd_data.dens;
               pres_in  = rd_data.pres;
               state_in = S_FINISH;
            end else begin
               state_in = S_CHKL;
            end
         end
         S_CHKL: begin
            // last point is also the answer when no interval brackets
            dres_in = rd_data.dens;
            pres_in = rd_data.pres;
            if (x_ge_rd) begin
               state_in = S_FINISH;
            end else begin
               idx_in   = lit_pkg::IDX_W'(1);
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (x_ge_lo && x_le_rd) begin
               hi_in    = rd_data;
               sel_in   = 1'b0;
               state_in = S_MUL;
            end else begin
               lo_in = rd_data;
               if (idx_ff == last_idx) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_FETCH;
               end
            end
         end
         S_MUL: begin
            if (den == '0) begin
               // zero-width interval answers the lower point
               if (sel_ff) begin
                  pres_in  = v1;
                  state_in = S_FINISH;
               end else begin
                  dres_in = v1[DENS_W-1:0];
                  sel_in  = 1'b1;
               end
            end else begin
               prod_in  = dx[ALT_W-1:0] * dv_mag;
               neg_in   = dv[VAL_W];
               den_in   = den[ALT_W-1:0];
               v1_in    = v1;
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            div_start = 1'b1;
            state_in  = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (div_stat.done) begin
               if (sel_ff) begin
                  pres_in  = div_res;
                  state_in = S_FINISH;
               end else begin
                  dres_in  = div_res[DENS_W-1:0];
                  sel_in   = 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_dens_in  = dres_ff;
               rsp_pres_in  = pres_ff;
               rsp_stat_in  = stat_ff;
               rsp_total_in = lit_pkg::TOTAL_W'(points_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         points_ff    <= '0;
         idx_ff       <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         points_ff    <= points_in;
         idx_ff       <= idx_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      den_ff       <= den_in;
      v1_ff        <= v1_in;
      dres_ff      <= dres_in;
      pres_ff      <= pres_in;
      stat_ff      <= stat_in;
      rsp_dens_ff  <= rsp_dens_in;
      rsp_pres_ff  <= rsp_pres_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_total_ff <= rsp_total_in;
   end

   lit_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (lit_pkg::IDX_W'(points_ff)),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   lit_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{lit_pkg::RSP_PAD_W{1'b0}}, rsp_total_ff, rsp_pres_ff, rsp_dens_ff};
   assign rsp_tuser  = rsp_stat_ff;

   `LIT_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req_tready)
   `LIT_ASSERT_IMP(a_points_bounded, clock, reset, 1'b1,
                   points_ff <= lit_pkg::CNT_W'(lit_pkg::TABLE_DEPTH))
   `LIT_ASSERT_IMP(a_div_start_idle, clock, reset, div_start, !div_stat.busy)
   `LIT_ASSERT_NXT(a_div_only_in_wait, clock, reset, div_stat.busy, state_ff == S_DIVWAIT)

endmodule

// File: tb/sv/tb_table_linear_interpolator_top.sv
// self-checking testbench for table_linear_interpolator_top: directed rows, then random
// table sessions with random idling on both channels; depends on lit_pkg and the rtl
module tb_table_linear_interpolator_top;

   localparam int ACTION_W    = lit_pkg::ACTION_W;
   localparam int ALT_W       = lit_pkg::ALT_W;
   localparam int DENS_W      = lit_pkg::DENS_W;
   localparam int PRES_W      = lit_pkg::PRES_W;
   localparam int STAT_W      = lit_pkg::STAT_W;
   localparam int TOTAL_W     = lit_pkg::TOTAL_W;
   localparam int TABLE_DEPTH = lit_pkg::TABLE_DEPTH;
   localparam int REQ_DATA_W  = lit_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W  = lit_pkg::RSP_DATA_W;

   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
   localparam int ITEM_TARGET = 450;
   localparam int CALM_AFTER  = 390;
   localparam int HOLD_AFTER  = 150;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 120;
   localparam int PLAN_ROWS   = 24;

   typedef struct packed {
      logic [DENS_W-1:0]  dens;
      logic [PRES_W-1:0]  pres;
      logic [STAT_W-1:0]  status;
      logic [TOTAL_W-1:0] total;
   } answer_type;

   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic [ALT_W-1:0]    alt;
      logic [DENS_W-1:0]   dens;
      logic [PRES_W-1:0]   pres;
      int                  reps;
      bit                  known;
      answer_type          want;
   } stim_row_type;

   // rows marked known carry their answer; repeated appends step the altitude by 256
   localparam stim_row_type PLAN [PLAN_ROWS] = '{
      '{lit_pkg::ACT_QUERY,  32'h0000_0000, 24'h0, 28'h0, 1, 1'b1,
        '{lit_pkg::DEF_DENSITY, lit_pkg::DEF_PRESSURE, lit_pkg::STAT_EMPTY, 5'd0}},
      '{ACT_SPARE,  32'hFFFF_FFFF, 24'hFF_FFFF, 28'hFFF_FFFF, 1, 1'b1,
        '{24'd0, 28'd0, lit_pkg::STAT_OK, 5'd0}},
      '{lit_pkg::ACT_APPEND, 32'h8000_0000, 24'h0, 28'h0, 1, 1'b1,
        '{24'd0, 28'd0, lit_pkg::STAT_OK, 5'd1}},
      '{lit_pkg::ACT_QUERY,  32'h8000_0000, 24'h0, 28'h0, 1, 1'b1,
        '{24'd0, 28'd0, lit_pkg::STAT_OK, 5'd1}},
      '{lit_pkg::ACT_QUERY,  32'hFFFF_FFFF, 24'h0, 28'h0, 1, 1'b1,
        '{24'd0, 28'd0, lit_pkg::STAT_OK, 5'd1}},
      '{lit_pkg::ACT_APPEND, 32'h0000_0000, 24'hFF_FFFF, 28'hFFF_FFFF, 1, 1'b1,
        '{24'd0, 28'd0, lit_pkg::STAT_OK, 5'd2}},
      '{lit_pkg::ACT_QUERY,  32'hC000_0000, 24'h0, 28'h0, 1, 1'b0, '0},
      '{lit_pkg::ACT_QUERY,  32'hFFFF_FFFF, 24'h0, 28'h0, 1, 1'b0, '0},
      '{lit_pkg::ACT_APPEND, 32'h0000_0000, 24'd5, 28'd7, 1, 1'b1,
        '{24'd0, 28'd0, lit_pkg::STAT_OK, 5'd3}},
      '{lit_pkg::ACT_APPEND, 32'h7FFF_FFFF, 24'd100, 28'd200, 1, 1'b1,
        '{24'd0, 28'd0, lit_pkg::STAT_OK, 5'd4}},
      '{lit_pkg::ACT_QUERY,  32'h0000_0000, 24'h0, 28'h0, 1, 1'b0, '0},
      '{lit_pkg::ACT_QUERY,  32'h0000_0001, 24'h0, 28'h0, 1, 1'b0, '0},
      '{lit_pkg::ACT_QUERY,  32'h7FFF_FFFF, 24'h0, 28'h0, 1, 1'b1,
        '{24'd100, 28'd200, lit_pkg::STAT_OK, 5'd4}},
      '{lit_pkg::ACT_QUERY,  32'h7FFF_FFFE, 24'h0, 28'h0, 1, 1'b0, '0},
      '{lit_pkg::ACT_APPEND, 32'h0000_03E8, 24'h12_3456, 28'hABC_DEF0, 12, 1'b0, '0},
      '{lit_pkg::ACT_APPEND, 32'h1234_5678, 24'h55_5555, 28'h555_5555, 1, 1'b1,
        '{24'd0, 28'd0, lit_pkg::STAT_FULL, 5'd16}},
      '{lit_pkg::ACT_QUERY,  32'h0000_01F4, 24'h0, 28'h0, 1, 1'b0, '0},
      '{lit_pkg::ACT_CLEAR,  32'hAAAA_AAAA, 24'hAA_AAAA, 28'hAAA_AAAA, 1, 1'b1,
        '{24'd0, 28'd0, lit_pkg::STAT_OK, 5'd0}},
      '{lit_pkg::ACT_APPEND, 32'h0000_6400, 24'd10, 28'd20, 1, 1'b0, '0},
      '{lit_pkg::ACT_APPEND, 32'hFFFF_9C00, 24'd30, 28'd40, 1, 1'b0, '0},
      '{lit_pkg::ACT_APPEND, 32'h0001_2C00, 24'd50, 28'd60, 1, 1'b0, '0},
      '{lit_pkg::ACT_QUERY,  32'h0000_0000, 24'h0, 28'h0, 1, 1'b0, '0},
      '{lit_pkg::ACT_QUERY,  32'h0000_C800, 24'h0, 28'h0, 1, 1'b0, '0},
      '{lit_pkg::ACT_CLEAR,  32'h0000_0000, 24'h0, 28'h0, 1, 1'b1,
        '{24'd0, 28'd0, lit_pkg::STAT_OK, 5'd0}}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [ACTION_W-1:0]   req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;

   logic signed [ALT_W-1:0] pt_alt  [TABLE_DEPTH];
   logic [DENS_W-1:0]       pt_dens [TABLE_DEPTH];
   logic [PRES_W-1:0]       pt_pres [TABLE_DEPTH];
   int                      pt_count;

   answer_type pending_answers [$];
   int         items_sent;
   int         fail_count;
   bit         calm;

   table_linear_interpolator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // v1 + (x - a1) * (v2 - v1) / (a2 - a1), quotient truncated toward zero
   function automatic logic [PRES_W-1:0] blend(logic signed [ALT_W-1:0] x,
                                               logic signed [ALT_W-1:0] a1,
                                               logic signed [ALT_W-1:0] a2,
                                               logic [PRES_W-1:0] v1,
                                               logic [PRES_W-1:0] v2);
      longint num, den, sum;
      num = (longint'(x) - longint'(a1)) * (longint'(v2) - longint'(v1));
      den = longint'(a2) - longint'(a1);
      if (den <= 0)
         return v1;
      sum = longint'(v1) + num / den;
      return sum[PRES_W-1:0];
   endfunction

   function automatic answer_type lookup_result(logic [ACTION_W-1:0] act,
                                                logic signed [ALT_W-1:0] x,
                                                logic [DENS_W-1:0] d,
                                                logic [PRES_W-1:0] p);
      answer_type r;
      int         n;
      bit         found;
      logic [PRES_W-1:0] wide;
      r = '0;
      found = 1'b0;
      case (act)
         lit_pkg::ACT_CLEAR: pt_count = 0;
         lit_pkg::ACT_APPEND: begin
            if (pt_count < TABLE_DEPTH) begin
               pt_alt[pt_count]  = x;
               pt_dens[pt_count] = d;
               pt_pres[pt_count] = p;
               pt_count++;
            end else begin
               r.status = lit_pkg::STAT_FULL;
            end
         end
         lit_pkg::ACT_QUERY: begin
            n = pt_count;
            if (n == 0) begin
               r.dens   = lit_pkg::DEF_DENSITY;
               r.pres   = lit_pkg::DEF_PRESSURE;
               r.status = lit_pkg::STAT_EMPTY;
            end else if (x <= pt_alt[0]) begin
               r.dens = pt_dens[0];
               r.pres = pt_pres[0];
            end else if (x >= pt_alt[n-1]) begin
               r.dens = pt_dens[n-1];
               r.pres = pt_pres[n-1];
            end else begin
               // no bracket found on an unordered table answers the last point
               r.dens = pt_dens[n-1];
               r.pres = pt_pres[n-1];
               for (int i = 0; i + 1 < n && !found; i++) begin
                  if (x >= pt_alt[i] && x <= pt_alt[i+1]) begin
                     wide   = blend(x, pt_alt[i], pt_alt[i+1],
                                    PRES_W'(pt_dens[i]), PRES_W'(pt_dens[i+1]));
                     r.dens = wide[DENS_W-1:0];
                     r.pres = blend(x, pt_alt[i], pt_alt[i+1], pt_pres[i], pt_pres[i+1]);
                     found  = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      r.total = pt_count[TOTAL_W-1:0];
      return r;
   endfunction

   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ALT_W-1:0] alt,
                            input logic [DENS_W-1:0] dens, input logic [PRES_W-1:0] pres,
                            input bit known = 1'b0, input answer_type want = '0);
      logic [REQ_DATA_W-1:0] word;
      answer_type            ans;
      word = '0;
      word[ALT_W-1:0]                = alt;
      word[ALT_W +: DENS_W]          = dens;
      word[ALT_W + DENS_W +: PRES_W] = pres;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      ans = lookup_result(act, alt, dens, pres);
      items_sent++;
      pending_answers.insert(pending_answers.size(), known ? want : ans);
   endtask

   initial begin
      int       alts [$];
      int       npts, nq, narrow;
      longint   span, off;
      logic [ALT_W-1:0] x;
      logic [ALT_W-1:0] base;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= lit_pkg::ACT_CLEAR;
      pt_count   = 0;
      items_sent = 0;
      fail_count = 0;
      calm       = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++)
         for (int k = 0; k < PLAN[r].reps; k++)
            send_item(PLAN[r].act, PLAN[r].alt + ALT_W'(k * 256), PLAN[r].dens,
                      PLAN[r].pres, PLAN[r].known, PLAN[r].want);

      while (items_sent < ITEM_TARGET) begin
         calm = items_sent >= CALM_AFTER;
         case ($urandom_range(0, 9))
            7, 8: begin
               repeat ($urandom_range(1, 5))
                  send_item(ACTION_W'($urandom_range(0, 3)), $urandom, DENS_W'($urandom),
                            PRES_W'($urandom));
            end
            9: begin
               // appends in arbitrary order on top of whatever is held
               repeat ($urandom_range(1, 4))
                  send_item(lit_pkg::ACT_APPEND, $urandom, DENS_W'($urandom),
                            PRES_W'($urandom));
               repeat ($urandom_range(1, 3))
                  send_item(lit_pkg::ACT_QUERY, $urandom, DENS_W'($urandom),
                            PRES_W'($urandom));
            end
            default: begin
               send_item(lit_pkg::ACT_CLEAR, $urandom, DENS_W'($urandom), PRES_W'($urandom));
               npts = ($urandom_range(0, 3) == 0) ? $urandom_range(9, TABLE_DEPTH)
                                                  : $urandom_range(1, 6);
               alts.delete();
               base   = $urandom;
               narrow = $urandom_range(0, 2);
               for (int i = 0; i < npts; i++) begin
                  case (narrow)
                     0: alts.insert(alts.size(), $urandom);
                     1: alts.insert(alts.size(), base + ALT_W'($urandom_range(0, 64)));
                     default: alts.insert(alts.size(), base + ALT_W'($urandom_range(0, 65535)));
                  endcase
               end
               alts.sort();
               foreach (alts[i])
                  send_item(lit_pkg::ACT_APPEND, alts[i], DENS_W'($urandom), PRES_W'($urandom));
               if (npts == TABLE_DEPTH && $urandom_range(0, 1) == 1)
                  send_item(lit_pkg::ACT_APPEND, $urandom, DENS_W'($urandom), PRES_W'($urandom));
               nq = $urandom_range(2, 8);
               for (int q = 0; q < nq; q++) begin
                  case ($urandom_range(0, 3))
                     0: x = alts[$urandom_range(0, alts.size() - 1)];
                     1: begin
                        span = longint'(alts[$]) - longint'(alts[0]);
                        off  = (longint'($urandom >> 1) * (span + 1)) >>> 31;
                        x    = ALT_W'(longint'(alts[0]) + off);
                     end
                     2: x = $urandom;
                     default: x = alts[$urandom_range(0, 1) ? 0 : alts.size() - 1]
                                  + ALT_W'($urandom_range(0, 2)) - ALT_W'(1);
                  endcase
                  send_item(lit_pkg::ACT_QUERY, x, DENS_W'($urandom), PRES_W'($urandom));
               end
            end
         endcase
      end
      req_tvalid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // result side: random stall bursts plus one long hold-off to back up the input
   initial begin
      int         stall_left;
      bit         held;
      answer_type want, got;
      stall_left = 0;
      held       = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.dens   = rsp_tdata[DENS_W-1:0];
            got.pres   = rsp_tdata[DENS_W +: PRES_W];
            got.total  = rsp_tdata[DENS_W + PRES_W +: TOTAL_W];
            got.status = rsp_tuser;
            if (pending_answers.size() == 0) begin
               $error("result transfer with no answer pending");
               fail_count++;
            end else begin
               want = pending_answers.pop_front();
               if (got.dens !== want.dens) begin
                  $error("density: expected %0d, got %0d", want.dens, got.dens);
                  fail_count++;
               end
               if (got.pres !== want.pres) begin
                  $error("pressure: expected %0d, got %0d", want.pres, got.pres);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.total !== want.total) begin
                  $error("point_total: expected %0d, got %0d", want.total, got.total);
                  fail_count++;
               end
            end
         end
         if (!held && items_sent >= HOLD_AFTER) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

endmodule
